// ===== rtl/core/fmmp_pkg.sv =====
// ----------------------------------------------------------------------------
// fmmp_pkg: shared types and constants
// Widths, state encoding and the controller/datapath command bundle.
// ----------------------------------------------------------------------------
package fmmp_pkg;

  localparam int INDEX_BITS = 64;
  localparam int MOD_BITS   = 32;
  localparam int PROD_BITS  = 2 * MOD_BITS;
  localparam int BIT_CNT_W  = $clog2(INDEX_BITS);
  localparam int RED_CNT_W  = $clog2(MOD_BITS + 1);
  localparam logic [MOD_BITS-1:0] MODULUS_RESET = MOD_BITS'(32'd1000000007);

  // matrix-multiply destination
  typedef enum logic [0:0] {
    DST_ACC  = 1'b0,
    DST_BASE = 1'b1
  } dst_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL_ACC,
    ST_WAIT_ACC,
    ST_SQR,
    ST_WAIT_SQR,
    ST_NEXT,
    ST_DONE
  } state_t;

  // multiply sequencer inside the datapath
  typedef enum logic [1:0] {
    MS_IDLE,
    MS_MUL,
    MS_RED
  } mstate_t;

  // controller -> datapath
  typedef struct packed {
    logic load;      // latch index and initialise matrices
    logic mul_start; // start a matrix multiply
    dst_t mul_dst;   // where the product goes
    logic shift;     // advance to the next index bit
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mul_done;
    logic cur_bit;
    logic last_bit;
  } dp_sts_t;

endpackage

// ===== rtl/core/fmmp_modred.sv =====
// ----------------------------------------------------------------------------
// fmmp_modred: iterative modular reduction
// Restoring reduction of a product below m*2^MOD_BITS, one bit per cycle.
// ----------------------------------------------------------------------------
module fmmp_modred
  import fmmp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [PROD_BITS-1:0] value,
  input  logic [MOD_BITS-1:0]  modulus,
  output logic                 done,
  output logic [MOD_BITS-1:0]  result
);

  logic [PROD_BITS-1:0] rem_r, rem_nxt;
  logic [RED_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [PROD_BITS:0]   shifted;
  logic [PROD_BITS:0]   trial;

  // trial subtract of m shifted to the current bit position
  always_comb begin
    shifted = {1'b0, PROD_BITS'(modulus)} << cnt_r;
    trial   = {1'b0, rem_r} - shifted;
  end

  always_comb begin
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      rem_nxt  = value;
      cnt_nxt  = RED_CNT_W'(MOD_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[PROD_BITS]) rem_nxt = trial[PROD_BITS-1:0];
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    cnt_r <= cnt_nxt;
  end

  assign done   = done_r;
  assign result = rem_r[MOD_BITS-1:0];

endmodule

// ===== rtl/core/fmmp_datapath.sv =====
// ----------------------------------------------------------------------------
// fmmp_datapath: matrix registers and shared multiply/reduce unit
// Each matrix multiply runs eight products in turn, each through one
// registered multiplier and the shared reducer, with modular adds.
// ----------------------------------------------------------------------------
module fmmp_datapath
  import fmmp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dp_cmd_t               cmd,
  input  logic [INDEX_BITS-1:0] index,
  input  logic [MOD_BITS-1:0]   modulus,
  output dp_sts_t               sts,
  output logic [MOD_BITS-1:0]   fib_value
);

  logic [MOD_BITS-1:0]   acc_r [4];
  logic [MOD_BITS-1:0]   base_r [4];
  logic [MOD_BITS-1:0]   res_r [4];
  logic [INDEX_BITS-1:0] n_r;
  logic [BIT_CNT_W-1:0]  bit_r;
  logic [2:0]            term_r;
  mstate_t               ms_r, ms_nxt;
  dst_t                  dst_r;
  logic [PROD_BITS-1:0]  prod_r;
  logic                  red_go_r, red_go_nxt;
  logic                  red_start;
  logic                  red_done;
  logic [MOD_BITS-1:0]   red_res;
  logic                  done_r, done_nxt;
  logic [MOD_BITS-1:0]   one_m;
  logic [MOD_BITS-1:0]   op_a, op_b;
  logic [MOD_BITS:0]     sum;
  logic [MOD_BITS:0]     sum_sub;
  logic [MOD_BITS-1:0]   sum_red;

  assign one_m = (modulus == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);

  // term t: entry (i,j) = t[2:1], half t[0]; c_ij = a_i0*b_0j + a_i1*b_1j
  always_comb begin
    op_a = acc_r[{term_r[2], term_r[0]}];
    if (dst_r == DST_BASE) op_a = base_r[{term_r[2], term_r[0]}];
    op_b = base_r[{term_r[0], term_r[1]}];
  end

  // modular add of a new reduced product into the entry sum; the first product of an entry is stored as is
  always_comb begin
    sum     = {1'b0, res_r[term_r[2:1]]} + {1'b0, red_res};
    sum_sub = sum - {1'b0, modulus};
    sum_red = sum_sub[MOD_BITS] ? sum[MOD_BITS-1:0] : sum_sub[MOD_BITS-1:0];
    if (!term_r[0]) sum_red = red_res;
  end

  // reducer starts once the registered product is in place
  assign red_start = red_go_r;

  fmmp_modred u_red (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (red_start),
    .value   (prod_r),
    .modulus (modulus),
    .done    (red_done),
    .result  (red_res)
  );

  // multiply sequencer: next state
  always_comb begin
    ms_nxt   = ms_r;
    done_nxt = 1'b0;
    unique case (ms_r)
      MS_IDLE: if (cmd.mul_start) ms_nxt = MS_MUL;
      MS_MUL:  ms_nxt = MS_RED;
      MS_RED: begin
        if (red_done) begin
          if (term_r == 3'd7) begin
            ms_nxt   = MS_IDLE;
            done_nxt = 1'b1;
          end else begin
            ms_nxt = MS_MUL;
          end
        end
      end
      default: ms_nxt = MS_IDLE;
    endcase
  end

  // multiply sequencer: outputs
  assign red_go_nxt = (ms_r == MS_MUL);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r     <= MS_IDLE;
      done_r   <= 1'b0;
      red_go_r <= 1'b0;
    end else begin
      ms_r     <= ms_nxt;
      done_r   <= done_nxt;
      red_go_r <= red_go_nxt;
    end
  end

  // operand, product and matrix registers
  always_ff @(posedge clk) begin
    if (cmd.mul_start) begin
      term_r <= '0;
      dst_r  <= cmd.mul_dst;
    end
    if (ms_r == MS_MUL) prod_r <= PROD_BITS'(op_a) * PROD_BITS'(op_b);
    if (ms_r == MS_RED && red_done) begin
      res_r[term_r[2:1]] <= sum_red;
      term_r <= term_r + 3'd1;
    end
    if (done_r) begin
      for (int k = 0; k < 4; k++) begin
        if (dst_r == DST_ACC) acc_r[k] <= res_r[k];
        else base_r[k] <= res_r[k];
      end
    end
    if (cmd.load) begin
      n_r       <= index;
      bit_r     <= '0;
      acc_r[0]  <= one_m;
      acc_r[1]  <= '0;
      acc_r[2]  <= '0;
      acc_r[3]  <= one_m;
      base_r[0] <= '0;
      base_r[1] <= one_m;
      base_r[2] <= one_m;
      base_r[3] <= one_m;
    end else if (cmd.shift) begin
      n_r   <= n_r >> 1;
      bit_r <= bit_r + 1'b1;
    end
  end

  assign sts.mul_done = done_r;
  assign sts.cur_bit  = n_r[0];
  assign sts.last_bit = (bit_r == BIT_CNT_W'(INDEX_BITS - 1));
  assign fib_value    = (modulus == '0) ? '0 : acc_r[2];

endmodule

// ===== rtl/core/fmmp_ctrl.sv =====
// ----------------------------------------------------------------------------
// fmmp_ctrl: sequencing controller
// Walks the index bits, ordering multiplies and squarings, and owns the
// input and output handshakes.
// ----------------------------------------------------------------------------
module fmmp_ctrl
  import fmmp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (in_valid) state_nxt = ST_MUL_ACC;
      ST_MUL_ACC:  state_nxt = sts.cur_bit ? ST_WAIT_ACC : ST_SQR;
      ST_WAIT_ACC: if (sts.mul_done) state_nxt = ST_SQR;
      ST_SQR:      state_nxt = sts.last_bit ? ST_DONE : ST_WAIT_SQR;
      ST_WAIT_SQR: if (sts.mul_done) state_nxt = ST_NEXT;
      ST_NEXT:     state_nxt = ST_MUL_ACC;
      ST_DONE:     if (out_ready) state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL_ACC: begin
        cmd.mul_start = sts.cur_bit;
        cmd.mul_dst   = DST_ACC;
      end
      ST_SQR: begin
        cmd.mul_start = !sts.last_bit;
        cmd.mul_dst   = DST_BASE;
      end
      ST_NEXT: cmd.shift = 1'b1;
      ST_DONE: out_valid = 1'b1;
      default: cmd = '0;
    endcase
  end

endmodule

// ===== rtl/core/fibonacci_mod_matrix_power_top.sv =====
// Each 2x2 multiply runs eight products in turn through the one-bit-per-cycle
//   reducer that all products share.
// One item at a time: the next item can be accepted in the cycle after the
//   result is taken. Reset (rst_n, synchronous, low) idles the controller and
//   sets the modulus to 1000000007.
// ----------------------------------------------------------------------------
// fibonacci_mod_matrix_power_top: F(n) mod m by matrix exponentiation
// Top level joining controller, datapath and modulus register.
// ----------------------------------------------------------------------------
module fibonacci_mod_matrix_power_top
  import fmmp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [INDEX_BITS-1:0] in_index,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [MOD_BITS-1:0]   out_fib_value,
  input  logic                  cfg_we,
  input  logic [MOD_BITS-1:0]   cfg_wdata
);

  logic [MOD_BITS-1:0] modulus_r;
  dp_cmd_t             cmd;
  dp_sts_t             sts;

  // modulus register
  always_ff @(posedge clk) begin
    if (!rst_n)      modulus_r <= MODULUS_RESET;
    else if (cfg_we) modulus_r <= cfg_wdata;
  end

  fmmp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fmmp_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .index     (in_index),
    .modulus   (modulus_r),
    .sts       (sts),
    .fib_value (out_fib_value)
  );

endmodule

// ===== rtl/core/fmmp_checker.sv =====
// ----------------------------------------------------------------------------
// fmmp_checker: port-level checks
// Handshake and sequencing properties seen at the top-level ports.
// ----------------------------------------------------------------------------
module fmmp_checker
  import fmmp_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [MOD_BITS-1:0] out_fib_value
);

  // result held while stalled
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_fib_value))
    else $error("result changed while stalled");

  // never ready for input while a result waits
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready with result pending");

  // an accepted item gives no result in the next cycle
  a_lat: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid && !in_ready)
    else $error("item finished too early");

  // after a result is taken the block is ready again
  a_ret: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready |=> in_ready)
    else $error("not ready after result taken");

endmodule

bind fibonacci_mod_matrix_power_top fmmp_checker u_fmmp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_valid),
  .in_ready      (in_ready),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_fib_value (out_fib_value)
);
